@@ sv/text_console_char_writer_defines.svh @@
// Assertion shorthands shared by the console writer.
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define TCCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define TCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/tccw_pkg.sv @@
package tccw_pkg;

	// Request fields
	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  char_code;
		logic [10:0] read_index;
	} cmd_t;

	// Response fields
	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [10:0] cursor_pos;
		logic [15:0] cell_data;
	} rsp_t;

	// Action codes
	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// Control characters
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;

	// Attribute after reset and the blank cell it gives
	localparam logic [7:0]  ATTR_RESET  = 8'h07;
	localparam logic [15:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

endpackage

@@ sv/tccw_ram.sv @@
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one port; the other port's read data is registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/text_console_char_writer.sv @@
// Text console writer over a ROWS x COLUMNS screen of 16-bit cells.
// cmd channel (cmd_valid/cmd_stall, payload cmd): put a character, clear
// the screen or read one cell. rsp channel (rsp_valid/rsp_stall, payload
// rsp): one response per request with the cursor after it and the cell read.
// cfg channel (cfg_valid/cfg_ready, cfg_data): attribute for new cells;
// write it only while no request is in flight.
// Requests share the single screen RAM: a tab writes spaces up to the
// next tab stop, a clear and a scroll sweep the RAM one cell per cycle,
// and a scroll copies each cell one row up through the registered read
// port and blanks the last row. A read beyond the screen skips the RAM.
// The response register loads as the request leaves the done state.
// After reset the block sweeps the RAM writing blank cells (0x0720) with
// cmd_stall high; cfg writes are taken meanwhile. The cursor is then at
// home and the attribute is 0x07 unless a cfg write changed it.
// A stalled response holds in the output register; the next request is
// still accepted and runs until its own response is due.
`include "text_console_char_writer_defines.svh"

module text_console_char_writer
	import tccw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  cmd_t       cmd,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);

	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
	localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TAB   = 3'd1;
	localparam logic [2:0] ST_SWEEP = 3'd2;
	localparam logic [2:0] ST_FLUSH = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic              copy_q, copy_d;
	logic [15:0]       blank_q, blank_d;
	logic              init_q, init_d;
	logic [15:0]       cell_q, cell_d;
	logic [7:0]        attr_q;

	logic              wr_v_s1;
	logic              wr_copy_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              ch_we;
	logic [ADDR_W-1:0] ch_waddr;
	logic [15:0]       ch_wdata;
	logic [ADDR_W-1:0] rd_addr;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic [15:0]       ram_rdata;

	logic [ADDR_W-1:0] cur_addr;
	logic [COL_W-1:0]  col_inc;
	logic [15:0]       space_cell;
	logic              col_last;
	logic              row_last;
	logic              cmd_take;
	logic              rsp_free;

	assign cur_addr   = ADDR_W'(row_q) * ROW_SPAN + ADDR_W'(col_q);
	assign col_inc    = col_q + 1'b1;
	assign space_cell = {attr_q, CH_SPACE};
	assign col_last   = (col_q == COL_LAST);
	assign row_last   = (row_q == ROW_LAST);
	assign cmd_stall  = (state_q != ST_IDLE);
	assign cmd_take   = cmd_valid && !cmd_stall;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign cfg_ready  = 1'b1;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// Sequence each request through the screen RAM
	always_comb begin
		state_d  = state_q;
		row_d    = row_q;
		col_d    = col_q;
		cnt_d    = cnt_q;
		copy_d   = copy_q;
		blank_d  = blank_q;
		init_d   = init_q;
		cell_d   = cell_q;
		ch_we    = 1'b0;
		ch_waddr = cur_addr;
		ch_wdata = {attr_q, cmd.char_code};
		rd_addr  = cnt_q + ROW_SPAN;
		case (state_q)
			ST_IDLE: begin
				if (cmd_take) begin
					cell_d  = '0;
					state_d = ST_DONE;
					case (cmd.action)
						ACT_PUT: begin
							case (cmd.char_code)
								CH_LF: begin
									col_d = '0;
									if (row_last) begin
										state_d = ST_SWEEP;
										cnt_d   = '0;
										copy_d  = 1'b1;
										blank_d = space_cell;
									end else begin
										row_d = row_q + 1'b1;
									end
								end
								CH_CR: begin
									col_d = '0;
								end
								CH_BS: begin
									if (col_q != '0) begin
										col_d    = col_q - 1'b1;
										ch_we    = 1'b1;
										ch_waddr = cur_addr - 1'b1;
										ch_wdata = space_cell;
									end
								end
								CH_TAB: begin
									state_d = ST_TAB;
								end
								default: begin
									ch_we = 1'b1;
									if (col_last) begin
										col_d = '0;
										if (row_last) begin
											state_d = ST_SWEEP;
											cnt_d   = '0;
											copy_d  = 1'b1;
											blank_d = space_cell;
										end else begin
											row_d = row_q + 1'b1;
										end
									end else begin
										col_d = col_inc;
									end
								end
							endcase
						end
						ACT_CLEAR: begin
							row_d   = '0;
							col_d   = '0;
							state_d = ST_SWEEP;
							cnt_d   = '0;
							copy_d  = 1'b0;
							blank_d = space_cell;
						end
						ACT_READ: begin
							if (32'(cmd.read_index) < CELLS) begin
								rd_addr = ADDR_W'(cmd.read_index);
								state_d = ST_READ;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			// Write one space a cycle up to the next tab stop
			ST_TAB: begin
				ch_we    = 1'b1;
				ch_wdata = space_cell;
				if (col_last) begin
					col_d = '0;
					if (row_last) begin
						state_d = ST_SWEEP;
						cnt_d   = '0;
						copy_d  = 1'b1;
						blank_d = space_cell;
					end else begin
						row_d   = row_q + 1'b1;
						state_d = ST_DONE;
					end
				end else begin
					col_d = col_inc;
					if (col_inc[2:0] == 3'd0) begin
						state_d = ST_DONE;
					end
				end
			end
			// Issue one cell per cycle; stage 1 does the write
			ST_SWEEP: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CELL_LAST) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				init_d  = 1'b0;
				state_d = init_q ? ST_IDLE : ST_DONE;
			end
			ST_READ: begin
				cell_d  = ram_rdata;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sweep writes take the port; single-cell writes never overlap them
	assign ram_we    = wr_v_s1 || ch_we;
	assign ram_waddr = wr_v_s1 ? wr_addr_s1 : ch_waddr;
	assign ram_wdata = wr_v_s1 ? (wr_copy_s1 ? ram_rdata : blank_q) : ch_wdata;

	tccw_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Control state; reset starts the blanking sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			row_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			copy_q      <= 1'b0;
			blank_q     <= BLANK_RESET;
			init_q      <= 1'b1;
			attr_q      <= ATTR_RESET;
			wr_v_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			cnt_q   <= cnt_d;
			copy_q  <= copy_d;
			blank_q <= blank_d;
			init_q  <= init_d;
			wr_v_s1 <= (state_q == ST_SWEEP);
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload: sweep stage and response register
	always_ff @(posedge clk) begin
		cell_q     <= cell_d;
		wr_addr_s1 <= cnt_q;
		wr_copy_s1 <= copy_q && (cnt_q < COPY_END);
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q.cursor_row <= 5'(row_q);
			rsp_q.cursor_col <= 7'(col_q);
			rsp_q.cursor_pos <= 11'(cur_addr);
			rsp_q.cell_data  <= cell_q;
		end
	end

	`TCCW_ASSERT_NEXT(a_take_leaves_idle, clk, arst_n, cmd_take, state_q != ST_IDLE,
		"accepted request did not start work")
	`TCCW_ASSERT_IMPLY(a_no_rsp_in_init, clk, arst_n, init_q, !rsp_valid_q,
		"response during the reset sweep")
	`TCCW_ASSERT_IMPLY(a_no_write_late, clk, arst_n,
		state_q == ST_READ || state_q == ST_DONE, !ram_we,
		"screen write outside the write phases")

endmodule
